// ===== hw/rtl/fcce_pkg.sv =====
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types, constants and helpers of the FAT32 cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = 28;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 3;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [ENTRY_W-1:0] LINK_MASK  = 28'hFFF_FFFF;
   localparam logic [ENTRY_W-1:0] EOC_LOW    = 28'hFFF_FFF8;
   localparam logic [ENTRY_W-1:0] BAD_VALUE  = 28'hFFF_FFF7;
   localparam logic [ENTRY_W-1:0] FIRST_DATA = 28'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_WALK   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_EOC   = 3'd1,
      ST_BAD   = 3'd2,
      ST_FREE  = 3'd3,
      ST_RANGE = 3'd4,
      ST_GUARD = 3'd5,
      ST_EMPTY = 3'd6,
      ST_ACK   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LOOK = 2'b10
   } state_type;

   // Register word index decoded from the APB byte address.
   typedef enum logic [0:0] {
      REG_ENTRY_COUNT = 1'b0
   } reg_type;

   // Classifies a link value: ST_OK when it can be followed.
   function automatic status_type link_class(input logic [ENTRY_W-1:0] v);
      status_type c;
      if (v >= EOC_LOW) begin
         c = ST_EOC;
      end else if (v == BAD_VALUE) begin
         c = ST_BAD;
      end else if (v == '0) begin
         c = ST_FREE;
      end else begin
         c = ST_OK;
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/fcce_if.sv =====
// ----------------------------------------------------------------------------
// fcce_req_if / fcce_rsp_if
// Valid/ready channels for requests and results of the cluster chain engine.
// ----------------------------------------------------------------------------
interface fcce_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [27:0] cluster;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;

   modport source (output valid, output cmd, output cluster, output byte0,
                   output byte1, output byte2, output byte3, input ready);
   modport sink   (input valid, input cmd, input cluster, input byte0,
                   input byte1, input byte2, input byte3, output ready);
endinterface

interface fcce_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] cluster_out;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, output cluster_out, output status, output last,
                   input ready);
   modport sink   (input valid, input cluster_out, input status, input last,
                   output ready);
endinterface

// ===== hw/rtl/fat32_cluster_chain_engine.sv =====
// ----------------------------------------------------------------------------
// fat32_cluster_chain_engine
// FAT32 allocation table store with next-cluster lookup and chain walking.
// ----------------------------------------------------------------------------
// The table lives in one synchronous RAM of DEPTH 28-bit entries; a valid bit
// per entry makes never-written entries read as zero, so no clearing pass runs
// after reset. A write or a mark-loaded request is answered in the cycle after
// it is accepted, as is any request answered without the table (out of range,
// not loaded, empty walk). A lookup reads the RAM and then classifies its data
// into the result register. A walk issues one RAM read per emitted cluster,
// since each read address is the link returned by the previous read. One
// request is handled at a time; a request is taken only while the result
// register is empty or being read, so a result that waits holds both the
// engine and the request channel.
module fat32_cluster_chain_engine (
   input  logic                           clock,
   input  logic                           reset,
   fcce_req_if.sink                       req,
   fcce_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fcce_pkg::PADDR_W-1:0]   paddr,
   input  logic [fcce_pkg::PDATA_W-1:0]   pwdata,
   output logic [fcce_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import fcce_pkg::*;

   state_type            state_ff, state_in;
   logic                 loaded_ff, loaded_in;
   logic                 walk_ff, walk_in;
   logic [ENTRY_W-1:0]   cur_ff, cur_in;
   logic [COUNT_W-1:0]   guard_ff, guard_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic                 rd_valid_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]   rsp_cluster_ff, rsp_cluster_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

   logic [COUNT_W-1:0]   eff_count;
   logic [ENTRY_W-1:0]   eff_wide;
   logic [ENTRY_W-1:0]   entry;
   status_type           cls;
   logic [COUNT_W-1:0]   guard_next;
   logic                 out_free;
   logic                 accept;
   logic                 csr_write;
   reg_type              csr_reg;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_reg   = reg_type'(paddr[PADDR_W-1]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      if (csr_reg == REG_ENTRY_COUNT) begin
         prdata = PDATA_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write && csr_reg == REG_ENTRY_COUNT) begin
         count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign eff_count = (count_ff > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : count_ff;
   assign eff_wide  = ENTRY_W'(eff_count);

   // ------------------------------------------------------------------
   // Table memory
   // ------------------------------------------------------------------
   fcce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_waddr = req.cluster[ADDR_W-1:0];
   assign ram_wdata = {req.byte3[3:0], req.byte2, req.byte1, req.byte0} & LINK_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[ram_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_valid_ff <= valid_ff[ram_raddr];
      end
   end

   // An entry that was never written reads as zero.
   assign entry      = rd_valid_ff ? ram_rdata : '0;
   assign cls        = link_class(entry);
   assign guard_next = guard_ff + 1'b1;

   // ------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in       = state_ff;
      loaded_in      = loaded_ff;
      walk_in        = walk_ff;
      cur_in         = cur_ff;
      guard_in       = guard_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = req.cluster[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = '0;
               rsp_last_in    = 1'b1;
               case (cmd_type'(req.cmd))
                  CMD_WRITE: begin
                     if (req.cluster < ENTRY_W'(DEPTH)) begin
                        ram_we        = 1'b1;
                        rsp_status_in = ST_ACK;
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  CMD_LOAD: begin
                     loaded_in     = 1'b1;
                     rsp_status_in = ST_ACK;
                  end
                  CMD_LOOKUP: begin
                     if (!loaded_ff || req.cluster >= eff_wide) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        walk_in      = 1'b0;
                        state_in     = S_LOOK;
                     end
                  end
                  CMD_WALK: begin
                     if (!loaded_ff || req.cluster < FIRST_DATA ||
                         req.cluster >= eff_wide) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        walk_in      = 1'b1;
                        cur_in       = req.cluster;
                        guard_in     = '0;
                        state_in     = S_LOOK;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_LOOK: begin
            // Read data holds while the result register is full.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (!walk_ff) begin
                  rsp_cluster_in = (cls == ST_OK) ? entry : '0;
                  rsp_status_in  = cls;
               end else begin
                  rsp_cluster_in = cur_ff;
                  if (cls != ST_OK) begin
                     rsp_status_in = cls;
                  end else if (entry < FIRST_DATA || entry >= eff_wide) begin
                     rsp_status_in = ST_RANGE;
                  end else if (guard_next >= eff_count) begin
                     rsp_status_in = ST_GUARD;
                  end else begin
                     // Follow the link: emit this member and read the next one.
                     rsp_status_in = ST_OK;
                     rsp_last_in   = 1'b0;
                     cur_in        = entry;
                     guard_in      = guard_next;
                     ram_re        = 1'b1;
                     ram_raddr     = entry[ADDR_W-1:0];
                     state_in      = S_LOOK;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= 1'b0;
         walk_ff      <= 1'b0;
         cur_ff       <= '0;
         guard_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         walk_ff      <= walk_in;
         cur_ff       <= cur_in;
         guard_ff     <= guard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cluster_out = rsp_cluster_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.last        = rsp_last_ff;
endmodule

// ===== hw/rtl/fcce_ram.sv =====
// ----------------------------------------------------------------------------
// fcce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== tb/sv/tb_fcce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fcce_checker
// Watches the request, result and register ports of the cluster chain engine.
// It keeps its own copy of the allocation table and the entry count, works
// out the results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module tb_fcce_checker (
   input  logic                          clock,
   input  logic                          reset,
   fcce_req_if                           req,
   fcce_rsp_if                           rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fcce_pkg::PADDR_W-1:0]  paddr,
   input  logic [fcce_pkg::PDATA_W-1:0]  pwdata,
   input  logic [fcce_pkg::PDATA_W-1:0]  prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            pending_results,
   output int                            checked_results
);
   import fcce_pkg::*;

   typedef struct packed {
      logic [ENTRY_W-1:0] cluster_out;
      status_type         status;
      logic               last;
   } chain_result_type;

   chain_result_type     chain_results_q[$];
   logic [ENTRY_W-1:0]   fat_copy [DEPTH];
   logic                 table_loaded;
   logic [COUNT_W-1:0]   entry_count_copy;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic add_result(input logic [ENTRY_W-1:0] cl_out, input status_type st,
                             input logic fin);
      chain_result_type r;
      r.cluster_out = cl_out;
      r.status      = st;
      r.last        = fin;
      chain_results_q.insert(chain_results_q.size(), r);
   endtask

   function automatic status_type classify_link(input logic [ENTRY_W-1:0] v);
      status_type c;
      if (v >= EOC_LOW) begin
         c = ST_EOC;
      end else if (v == BAD_VALUE) begin
         c = ST_BAD;
      end else if (v == '0) begin
         c = ST_FREE;
      end else begin
         c = ST_OK;
      end
      return c;
   endfunction

   task automatic predict_results(input logic [CMD_W-1:0] cmd,
                                  input logic [ENTRY_W-1:0] cl,
                                  input logic [31:0] raw);
      int unsigned        span;
      int unsigned        steps;
      logic [ENTRY_W-1:0] cur;
      logic [ENTRY_W-1:0] nxt;
      status_type         cls;
      status_type         stop;
      chain_result_type   held;
      bit                 have_held;
      bit                 done;
      span = (entry_count_copy < DEPTH) ? entry_count_copy : DEPTH;
      case (cmd)
         CMD_WRITE: begin
            if (cl < DEPTH) begin
               fat_copy[cl[ADDR_W-1:0]] = raw[ENTRY_W-1:0];
               add_result('0, ST_ACK, 1'b1);
            end else begin
               add_result('0, ST_RANGE, 1'b1);
            end
         end
         CMD_LOAD: begin
            table_loaded = 1'b1;
            add_result('0, ST_ACK, 1'b1);
         end
         CMD_LOOKUP: begin
            if (!table_loaded || cl >= span) begin
               add_result('0, ST_RANGE, 1'b1);
            end else begin
               nxt = fat_copy[cl[ADDR_W-1:0]];
               cls = classify_link(nxt);
               add_result((cls == ST_OK) ? nxt : '0, cls, 1'b1);
            end
         end
         default: begin
            if (!table_loaded || cl < FIRST_DATA || cl >= span) begin
               add_result('0, ST_EMPTY, 1'b1);
            end else begin
               // Each cluster is held back one step so that the final one can
               // take the stop reason and the last flag.
               cur = cl;
               steps = 0;
               stop = ST_GUARD;
               have_held = 1'b0;
               done = 1'b0;
               while (steps < span && !done) begin
                  if (have_held) add_result(held.cluster_out, held.status, held.last);
                  held = '{cur, ST_OK, 1'b0};
                  have_held = 1'b1;
                  nxt = fat_copy[cur[ADDR_W-1:0]];
                  cls = classify_link(nxt);
                  if (cls != ST_OK) begin
                     stop = cls;
                     done = 1'b1;
                  end else begin
                     steps++;
                     if (nxt < FIRST_DATA || nxt >= span) begin
                        stop = ST_RANGE;
                        done = 1'b1;
                     end
                     cur = nxt;
                  end
               end
               held.status = stop;
               held.last = 1'b1;
               add_result(held.cluster_out, held.status, held.last);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      chain_result_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) fat_copy[i] = '0;
         table_loaded = 1'b0;
         entry_count_copy = '0;
         chain_results_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            checked_results++;
            if (chain_results_q.size() == 0) begin
               report_mismatch("result with no request pending", 32'(rsp.status), 32'd0);
            end else begin
               want = chain_results_q.pop_front();
               if (rsp.cluster_out !== want.cluster_out)
                  report_mismatch("cluster_out", 32'(rsp.cluster_out),
                                  32'(want.cluster_out));
               if (rsp.status !== want.status)
                  report_mismatch("status", 32'(rsp.status), 32'(want.status));
               if (rsp.last !== want.last)
                  report_mismatch("last", 32'(rsp.last), 32'(want.last));
            end
         end
         if (req.valid && req.ready)
            predict_results(req.cmd, req.cluster,
                            {4'h0, req.byte3[3:0], req.byte2, req.byte1, req.byte0});
         if (psel && penable && pready && (paddr >> 2) == REG_ENTRY_COUNT) begin
            if (pwrite) begin
               entry_count_copy = pwdata[COUNT_W-1:0];
            end else if (prdata !== {{(PDATA_W-COUNT_W){1'b0}}, entry_count_copy}) begin
               report_mismatch("entry_count read", prdata, 32'(entry_count_copy));
            end
         end
      end
      pending_results = chain_results_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the FAT32 cluster chain engine: a directed pass over writes,
// lookups and walks that end in every stop reason, then random table builds,
// lookups and walks under several entry counts and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import fcce_pkg::*;

   localparam int REG_SPARE_INDEX = 1;
   localparam int ITEMS_PER_PHASE = 94;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int                  idle_pct;
   int                  stall_pct;
   int unsigned         span;
   int                  fail_count;
   int                  pending_results;
   int                  checked_results;
   int                  sent_per_cmd [4];

   fcce_req_if req_bus ();
   fcce_rsp_if rsp_bus ();

   fat32_cluster_chain_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tb_fcce_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_bus),
      .rsp             (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .checked_results (checked_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   initial begin
      #10ms;
      $display("[fat32_cluster_chain_engine] ERROR");
      $finish;
   end

   // Returns just after the edge that accepted the request; valid stays high
   // until the next falling edge decides on the following request.
   task automatic send_request(input cmd_type cmd, input logic [ENTRY_W-1:0] cl,
                               input logic [31:0] raw);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.cluster <= cl;
      req_bus.byte0   <= raw[7:0];
      req_bus.byte1   <= raw[15:8];
      req_bus.byte2   <= raw[23:16];
      req_bus.byte3   <= raw[31:24];
      do @(posedge clock); while (!req_bus.ready);
      sent_per_cmd[cmd]++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Upper data bits are random; only the low bits belong to the register.
   task automatic set_entry_count(input logic [COUNT_W-1:0] value);
      csr_access(1'b1, PADDR_W'(REG_ENTRY_COUNT * 4),
                 ($urandom & ~32'(2**COUNT_W - 1)) | 32'(value));
      csr_access(1'b0, PADDR_W'(REG_ENTRY_COUNT * 4), '0);
      span = (value < DEPTH) ? value : DEPTH;
   endtask

   initial begin
      int               phase_idle  [4];
      int               phase_stall [4];
      int               phase_count [4];
      int               kind;
      int               sel;
      logic [31:0]      raw;
      logic [ENTRY_W-1:0] cl;
      phase_idle  = '{0, 64, 0, 15};
      phase_stall = '{0, 0, 64, 15};
      phase_count = '{64, 127, 0, 40};
      phase_count[2] = $urandom_range(3, 63);
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_WRITE;
      req_bus.cluster = '0;
      req_bus.byte0 = '0;
      req_bus.byte1 = '0;
      req_bus.byte2 = '0;
      req_bus.byte3 = '0;
      idle_pct = 0;
      stall_pct = 0;
      span = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Before the table is loaded, lookups and walks must be refused.
      send_request(CMD_LOOKUP, 28'd2, '0);
      send_request(CMD_WALK, 28'd2, '0);
      send_request(CMD_WRITE, LINK_MASK, 32'hFFFF_FFFF);
      wait_drained();
      csr_access(1'b1, PADDR_W'(REG_SPARE_INDEX * 4), 32'h7F);
      set_entry_count(7'd16);

      // Chains: 2-3-4 ends, 7 links to a bad entry, 6 is free, 8 and 9 loop,
      // 10 links below the data area and 11 beyond the entry count.
      send_request(CMD_WRITE, 28'd2, 32'h0000_0003);
      send_request(CMD_WRITE, 28'd3, 32'hF000_0004);
      send_request(CMD_WRITE, 28'd4, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 28'd5, {4'h0, BAD_VALUE});
      send_request(CMD_WRITE, 28'd6, 32'hF000_0000);
      send_request(CMD_WRITE, 28'd7, 32'h0000_0005);
      send_request(CMD_WRITE, 28'd8, 32'h0000_0009);
      send_request(CMD_WRITE, 28'd9, 32'h0000_0008);
      send_request(CMD_WRITE, 28'd10, 32'h0000_0001);
      send_request(CMD_WRITE, 28'd11, 32'h0000_0028);
      send_request(CMD_WRITE, 28'(DEPTH - 1), {4'h0, EOC_LOW});
      send_request(CMD_LOAD, '0, '0);
      send_request(CMD_LOOKUP, 28'd2, '0);
      send_request(CMD_LOOKUP, 28'd4, '0);
      send_request(CMD_LOOKUP, 28'd5, '0);
      send_request(CMD_LOOKUP, 28'd6, '0);
      send_request(CMD_LOOKUP, 28'd16, '0);
      send_request(CMD_WALK, 28'd2, '0);
      send_request(CMD_WALK, 28'd7, '0);
      send_request(CMD_WALK, 28'd6, '0);
      send_request(CMD_WALK, 28'd8, '0);
      send_request(CMD_WALK, 28'd10, '0);
      send_request(CMD_WALK, 28'd11, '0);
      send_request(CMD_WALK, 28'd1, '0);
      wait_drained();

      // Entry count extremes: nothing in use, then more than the table holds.
      set_entry_count(7'd0);
      send_request(CMD_LOOKUP, 28'd0, '0);
      send_request(CMD_WALK, 28'd2, '0);
      wait_drained();
      set_entry_count(7'd127);
      send_request(CMD_WALK, 28'd8, '0);
      send_request(CMD_LOOKUP, 28'(DEPTH - 1), '0);
      wait_drained();
      set_entry_count(7'd1);
      send_request(CMD_LOOKUP, 28'd0, '0);
      send_request(CMD_WALK, 28'd2, '0);

      for (int p = 0; p < 4; p++) begin
         wait_drained();
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         set_entry_count(phase_count[p][COUNT_W-1:0]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == ITEMS_PER_PHASE / 2) wait_drained();
            kind = $urandom_range(99);
            sel = $urandom_range(99);
            if (kind < 35) begin
               // Mostly links inside the entry count, so that walks run long.
               if (sel < 60) begin
                  raw = {4'($urandom_range(15)),
                         28'($urandom_range(FIRST_DATA, span - 1))};
               end else if (sel < 70) begin
                  raw = {4'($urandom_range(15)), 28'(EOC_LOW + $urandom_range(7))};
               end else if (sel < 78) begin
                  raw = {4'($urandom_range(15)), BAD_VALUE};
               end else if (sel < 86) begin
                  raw = {4'($urandom_range(15)), 28'd0};
               end else begin
                  raw = $urandom;
               end
               sel = $urandom_range(99);
               if (sel < 75) begin
                  cl = 28'($urandom_range(0, span + 1));
               end else if (sel < 92) begin
                  cl = 28'($urandom_range(DEPTH - 1));
               end else begin
                  cl = 28'($urandom);
               end
               send_request(CMD_WRITE, cl, raw);
            end else if (kind < 38) begin
               send_request(CMD_LOAD, 28'($urandom), $urandom);
            end else begin
               cl = (sel < 90) ? 28'($urandom_range(0, span + 1)) : 28'($urandom);
               send_request((kind < 65) ? CMD_LOOKUP : CMD_WALK, cl, $urandom);
            end
         end
      end

      wait_drained();
      repeat (10) @(negedge clock);
      $display("Run covered %0d writes, %0d loads, %0d lookups and %0d walks; %0d results.",
               sent_per_cmd[CMD_WRITE], sent_per_cmd[CMD_LOAD],
               sent_per_cmd[CMD_LOOKUP], sent_per_cmd[CMD_WALK], checked_results);
      $display("Entry counts 0, 1, 16, 40, 64, 127 and %0d under four idling patterns.",
               phase_count[2]);
      if (fail_count == 0) begin
         $display("[fat32_cluster_chain_engine] OK");
      end else begin
         $display("[fat32_cluster_chain_engine] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fcce_pkg.sv
hw/rtl/fcce_if.sv
hw/rtl/fcce_ram.sv
hw/rtl/fat32_cluster_chain_engine.sv
tb/sv/tb_fcce_checker.sv
tb/sv/tb_top.sv
